// ===== sv/cls_pkg.sv =====
`timescale 1ns / 1ps

package cls_pkg;

    // Fixed geometry of the solver
    localparam int ORDER_MAX = 16;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 64;
    localparam int FRAC_W    = 16;
    localparam int SIZE_W    = 5;

    // Item kinds
    localparam logic [1:0] KIND_MAT   = 2'd0;
    localparam logic [1:0] KIND_RHS   = 2'd1;
    localparam logic [1:0] KIND_SOLVE = 2'd2;

    // Register indexes
    localparam logic REG_SIZE = 1'b0;

    // Solve phases
    localparam logic [1:0] PH_FACT = 2'd0;
    localparam logic [1:0] PH_FWD  = 2'd1;
    localparam logic [1:0] PH_BWD  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              mat_we;
        logic              rhs_we;
        logic [1:0]        phase;
        logic [IDX_W-1:0]  i;
        logic [IDX_W-1:0]  j;
        logic [IDX_W-1:0]  k;
        logic              dot_rd;
        logic              mul_en;
        logic              acc_clr;
        logic              acc_en;
        logic              base_rd;
        logic              num_en;
        logic              sqrt_start;
        logic              div_start;
        logic              res_we;
        logic              out_rd;
        logic              out_load;
        logic              err_load;
        logic              out_last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic num_nonpos;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== sv/cls_sqrt.sv =====
`timescale 1ns / 1ps

module cls_sqrt
    import cls_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ACC_W-1:0]   i_radicand,
    output logic               o_done,
    output logic [VAL_W-1:0]   o_root
);

    localparam int ROOT_W = ACC_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [ACC_W-1:0]  r_rad, n_rad;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // Two radicand bits per step, one root bit per step
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[ACC_W-1 -: 2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, r_root, 2'b01};
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = {r_rad[ACC_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
    end

    // Root saturates to the largest positive value
    assign o_done = r_done;
    assign o_root = r_root[ROOT_W-1] ? {1'b0, {(VAL_W-1){1'b1}}} : r_root[VAL_W-1:0];

endmodule

// ===== sv/cls_div.sv =====
`timescale 1ns / 1ps

module cls_div
    import cls_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [ACC_W-1:0]  i_dividend,
    input  logic signed [VAL_W-1:0]  i_divisor,
    output logic                     o_done,
    output logic [VAL_W-1:0]         o_quot
);

    localparam int CNT_W = $clog2(ACC_W);

    logic [ACC_W-1:0] r_q, n_q;
    logic [VAL_W-1:0] r_rem, n_rem;
    logic [VAL_W-1:0] r_dvs, n_dvs;
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [VAL_W:0]   rem_sh;
    logic [ACC_W-1:0] mag_q;
    logic [ACC_W-1:0] pos_lim;
    logic [ACC_W-1:0] neg_lim;

    // Restoring division on magnitudes, one quotient bit per step
    always_comb begin
        rem_sh = {r_rem, r_q[ACC_W-1]};
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend[ACC_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_dvs  = i_divisor[VAL_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            n_neg  = i_dividend[ACC_W-1] ^ i_divisor[VAL_W-1];
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = VAL_W'(rem_sh - {1'b0, r_dvs});
                n_q   = {r_q[ACC_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[VAL_W-1:0];
                n_q   = {r_q[ACC_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ACC_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
    end

    // Sign and saturation of the truncated quotient
    always_comb begin
        mag_q   = r_q;
        pos_lim = {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
        neg_lim = {{(ACC_W-VAL_W){1'b0}}, 1'b1, {(VAL_W-1){1'b0}}};
        if (!r_neg) begin
            o_quot = (mag_q > pos_lim) ? pos_lim[VAL_W-1:0] : mag_q[VAL_W-1:0];
        end else begin
            o_quot = (mag_q > neg_lim) ? neg_lim[VAL_W-1:0] : (~mag_q[VAL_W-1:0] + 1'b1);
        end
    end

    assign o_done = r_done;

endmodule

// ===== sv/cls_datapath.sv =====
`timescale 1ns / 1ps

module cls_datapath
    import cls_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic [IDX_W-1:0]         i_row_index,
    input  logic [IDX_W-1:0]         i_col_index,
    input  logic signed [VAL_W-1:0]  i_entry_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [VAL_W-1:0]  o_solution_value,
    output logic [IDX_W-1:0]         o_solution_index,
    output logic                     o_last_entry,
    output logic                     o_not_positive_definite
);

    localparam int ADDR_W = 2 * IDX_W;

    // Stores
    logic [VAL_W-1:0] r_mat [ORDER_MAX*ORDER_MAX];
    logic [VAL_W-1:0] r_fac [ORDER_MAX*ORDER_MAX];
    logic [VAL_W-1:0] r_rhs [ORDER_MAX];
    logic [VAL_W-1:0] r_y   [ORDER_MAX];
    logic [VAL_W-1:0] r_x   [ORDER_MAX];

    logic signed [VAL_W-1:0] r_mat_q, r_pa_q, r_pb_q, r_rhs_q, r_y_q, r_x_q;
    logic signed [ACC_W-1:0] r_prod, r_acc, r_num;
    logic signed [VAL_W-1:0] r_dvs;
    logic                    r_out_valid;
    logic [VAL_W-1:0]        r_out_val;
    logic [IDX_W-1:0]        r_out_idx;
    logic                    r_out_last, r_out_err;

    logic [ADDR_W-1:0]       pa_addr, pb_addr, mat_addr, res_addr;
    logic [IDX_W-1:0]        y_addr, x_addr;
    logic signed [VAL_W-1:0] opb, base, res_val;
    logic signed [ACC_W-1:0] base_ext;
    logic                    diag;
    logic                    sqrt_done, div_done;
    logic [VAL_W-1:0]        root, quot;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sub(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_sub = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_sub = s[ACC_W-1:0];
        end
    endfunction

    // Address generation per phase
    always_comb begin
        diag     = (i_cmd.phase == PH_FACT) && (i_cmd.i == i_cmd.j);
        pb_addr  = {i_cmd.j, i_cmd.k};
        mat_addr = {i_cmd.i, i_cmd.j};
        y_addr   = i_cmd.k;
        x_addr   = i_cmd.k;
        res_addr = {i_cmd.i, i_cmd.j};
        if (i_cmd.base_rd) begin
            pa_addr = (i_cmd.phase == PH_FACT) ? {i_cmd.j, i_cmd.j} : {i_cmd.i, i_cmd.i};
            y_addr  = i_cmd.i;
        end else if (i_cmd.phase == PH_BWD) begin
            pa_addr = {i_cmd.k, i_cmd.i};
        end else begin
            pa_addr = {i_cmd.i, i_cmd.k};
        end
    end

    // Memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_we) begin
            r_mat[{i_row_index, i_col_index}] <= i_entry_value;
        end
        if (i_cmd.rhs_we) begin
            r_rhs[i_row_index] <= i_entry_value;
        end
        if (i_cmd.res_we) begin
            case (i_cmd.phase)
                PH_FACT: r_fac[res_addr] <= res_val;
                PH_FWD:  r_y[i_cmd.i]    <= res_val;
                PH_BWD:  r_x[i_cmd.i]    <= res_val;
                default: ;
            endcase
        end
        r_mat_q <= r_mat[mat_addr];
        r_pa_q  <= r_fac[pa_addr];
        r_pb_q  <= r_fac[pb_addr];
        r_rhs_q <= r_rhs[i_cmd.i];
        r_y_q   <= r_y[y_addr];
        r_x_q   <= r_x[x_addr];
    end

    // Operand selection
    always_comb begin
        case (i_cmd.phase)
            PH_FWD: begin
                opb  = r_y_q;
                base = r_rhs_q;
            end
            PH_BWD: begin
                opb  = r_x_q;
                base = r_y_q;
            end
            default: begin
                opb  = r_pb_q;
                base = r_mat_q;
            end
        endcase
        base_ext = {{(ACC_W-VAL_W-FRAC_W){base[VAL_W-1]}}, base, {FRAC_W{1'b0}}};
        res_val  = diag ? root : quot;
    end

    // Multiply, accumulate, difference
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= r_pa_q * opb;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= sat_add(r_acc, r_prod);
        end
        if (i_cmd.num_en) begin
            r_num <= sat_sub(base_ext, r_acc);
            r_dvs <= r_pa_q;
        end
    end

    cls_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (r_num),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    cls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_num),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load || i_cmd.err_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_val  <= r_x_q;
            r_out_idx  <= i_cmd.k;
            r_out_last <= i_cmd.out_last;
            r_out_err  <= 1'b0;
        end else if (i_cmd.err_load) begin
            r_out_val  <= '0;
            r_out_idx  <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end
    end

    assign o_status.num_nonpos = (r_num[ACC_W-1] || (r_num == '0));
    assign o_status.sqrt_done  = sqrt_done;
    assign o_status.div_done   = div_done;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid             = r_out_valid;
    assign o_solution_value        = r_out_val;
    assign o_solution_index        = r_out_idx;
    assign o_last_entry            = r_out_last;
    assign o_not_positive_definite = r_out_err;

endmodule

// ===== sv/cls_ctrl.sv =====
`timescale 1ns / 1ps

module cls_ctrl
    import cls_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cmd               o_cmd,
    input  t_status            i_status
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_DOT_RD   = 4'd2;
    localparam logic [3:0] S_DOT_MUL  = 4'd3;
    localparam logic [3:0] S_DOT_ACC  = 4'd4;
    localparam logic [3:0] S_BASE_RD  = 4'd5;
    localparam logic [3:0] S_BASE_SUB = 4'd6;
    localparam logic [3:0] S_CHECK    = 4'd7;
    localparam logic [3:0] S_WAIT     = 4'd8;
    localparam logic [3:0] S_WRITE    = 4'd9;
    localparam logic [3:0] S_OUT_RD   = 4'd10;
    localparam logic [3:0] S_OUT_LD   = 4'd11;
    localparam logic [3:0] S_ERR      = 4'd12;

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_phase, n_phase;
    logic [IDX_W-1:0]  r_i, n_i, r_j, n_j, r_k, n_k;
    logic [SIZE_W-1:0] r_size;
    logic [IDX_W-1:0]  last;
    logic              accept;
    logic              diag;
    logic              dot_empty;
    logic [IDX_W-1:0]  k_start, k_end;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(ORDER_MAX);
        end else if (psel && penable && pwrite && (paddr[2] == REG_SIZE)) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SIZE) ? {{(32-SIZE_W){1'b0}}, r_size} : 32'd0;

    // Effective order (clamped to 1..ORDER_MAX) minus one
    always_comb begin
        if (r_size == '0) begin
            last = '0;
        end else if (r_size >= SIZE_W'(ORDER_MAX)) begin
            last = IDX_W'(ORDER_MAX - 1);
        end else begin
            last = IDX_W'(r_size - 1'b1);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign diag       = (r_phase == PH_FACT) && (r_i == r_j);

    // Inner product range per phase
    always_comb begin
        case (r_phase)
            PH_FWD: begin
                dot_empty = (r_i == '0);
                k_start   = '0;
                k_end     = r_i - 1'b1;
            end
            PH_BWD: begin
                dot_empty = (r_i == last);
                k_start   = r_i + 1'b1;
                k_end     = last;
            end
            default: begin
                dot_empty = (r_j == '0);
                k_start   = '0;
                k_end     = r_j - 1'b1;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.phase    = r_phase;
        o_cmd.i        = r_i;
        o_cmd.j        = r_j;
        o_cmd.k        = r_k;
        o_cmd.out_last = (r_k == last);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.mat_we = (i_kind == KIND_MAT);
                    o_cmd.rhs_we = (i_kind == KIND_RHS);
                    if (i_kind == KIND_SOLVE) begin
                        n_phase = PH_FACT;
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.acc_clr = 1'b1;
                n_k     = k_start;
                n_state = dot_empty ? S_BASE_RD : S_DOT_RD;
            end
            S_DOT_RD: begin
                o_cmd.dot_rd = 1'b1;
                n_state = S_DOT_MUL;
            end
            S_DOT_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_DOT_ACC;
            end
            S_DOT_ACC: begin
                o_cmd.acc_en = 1'b1;
                if (r_k == k_end) begin
                    n_state = S_BASE_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_DOT_RD;
                end
            end
            S_BASE_RD: begin
                o_cmd.base_rd = 1'b1;
                n_state = S_BASE_SUB;
            end
            S_BASE_SUB: begin
                o_cmd.num_en = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (diag && i_status.num_nonpos) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.sqrt_start = diag;
                    o_cmd.div_start  = !diag;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (diag ? i_status.sqrt_done : i_status.div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.res_we = 1'b1;
                n_state = S_START;
                case (r_phase)
                    PH_FACT: begin
                        if (r_i != last) begin
                            n_i = r_i + 1'b1;
                        end else if (r_j != last) begin
                            n_j = r_j + 1'b1;
                            n_i = r_j + 1'b1;
                        end else begin
                            n_phase = PH_FWD;
                            n_i     = '0;
                        end
                    end
                    PH_FWD: begin
                        if (r_i != last) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            n_phase = PH_BWD;
                            n_i     = last;
                        end
                    end
                    default: begin
                        if (r_i != '0) begin
                            n_i = r_i - 1'b1;
                        end else begin
                            n_k     = '0;
                            n_state = S_OUT_RD;
                        end
                    end
                endcase
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_k == last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.err_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_FACT;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

endmodule

// ===== sv/cholesky_linear_solve_top.sv =====
`timescale 1ns / 1ps

// Cholesky solver for A*x = b, order 1 to 16, signed Q16.16 values. Matrix
// entries (kind 0, lower triangle is used) and right-hand side entries
// (kind 1) are loaded one transfer per cycle; a kind 2 transfer starts a
// solve of order size_in_use (APB register at address 0; 0 acts as 1, above
// 16 as 16). The solve factors A = L*Lt, then runs forward and backward
// substitution, and returns x[0] to x[n-1] in order with the last one
// marked; a pivot that is not positive yields a single result with the error
// flag set and value zero. No new transfer is taken while a solve runs. One
// shared multiply-accumulate handles every inner product, each term
// passing through read, multiply and accumulate steps; each pivot then
// takes a square root and each other element of L, y and x a divide.
// Stores are not cleared at reset.
module cholesky_linear_solve_top
    import cls_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_kind,
    input  logic [IDX_W-1:0]         i_row_index,
    input  logic [IDX_W-1:0]         i_col_index,
    input  logic signed [VAL_W-1:0]  i_entry_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [VAL_W-1:0]  o_solution_value,
    output logic [IDX_W-1:0]         o_solution_index,
    output logic                     o_last_entry,
    output logic                     o_not_positive_definite,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    t_cmd    cmd;
    t_status status;

    cls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    cls_datapath u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (cmd),
        .o_status                (status),
        .i_row_index             (i_row_index),
        .i_col_index             (i_col_index),
        .i_entry_value           (i_entry_value),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_solution_value        (o_solution_value),
        .o_solution_index        (o_solution_index),
        .o_last_entry            (o_last_entry),
        .o_not_positive_definite (o_not_positive_definite)
    );

endmodule
